@@ sv/kef_pkg.sv @@
// Shared types and constants of the keypad event queue controller.
package kef_pkg;

    // Queue and matrix geometry.
    localparam int FIFO_DEPTH  = 31;
    localparam int MATRIX_ROWS = 4;
    localparam int MATRIX_COLS = 9;
    localparam int KEY_TOTAL   = MATRIX_ROWS * MATRIX_COLS;

    localparam int QPTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int KADDR_W = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;
    localparam int EVENT_W = 9;

    // Item operations.
    typedef enum logic [2:0] {
        OP_KEY  = 3'd0,
        OP_ADDR = 3'd1,
        OP_RX   = 3'd2,
        OP_TX   = 3'd3,
        OP_STOP = 3'd4
    } t_op;

    // Register pointer machine.
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RX_REG    = 3'd1,
        PH_RX_DAT    = 3'd2,
        PH_TX_FIRST  = 3'd3,
        PH_TX_SECOND = 3'd4
    } t_bus_phase;

    // Bus register numbers.
    localparam logic [6:0] REG_VERSION   = 7'd1;
    localparam logic [6:0] REG_CONTROL   = 7'd2;
    localparam logic [6:0] REG_INT       = 7'd3;
    localparam logic [6:0] REG_COUNT     = 7'd4;
    localparam logic [6:0] REG_BACKLIGHT = 7'd5;
    localparam logic [6:0] REG_DEBOUNCE  = 7'd6;
    localparam logic [6:0] REG_RATE      = 7'd7;
    localparam logic [6:0] REG_RESET     = 7'd8;
    localparam logic [6:0] REG_EVENT     = 7'd9;

    localparam int WRITE_FLAG_BIT    = 7;
    localparam int CTL_OVERWRITE_BIT = 0;
    localparam int CTL_FLAG_OVF_BIT  = 1;
    localparam int IRQ_OVF_BIT       = 0;
    localparam int IRQ_KEY_BIT       = 1;

    localparam logic [7:0] VERSION_VALUE  = 8'h04;
    localparam logic [7:0] CTL_RESET      = 8'd2;
    localparam logic [7:0] DEBOUNCE_RESET = 8'd1;
    localparam logic [7:0] RATE_RESET     = 8'd5;

endpackage

@@ sv/kef_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kef_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/keypad_event_fifo_i2c_target.sv @@
// Top level of the keypad controller with its key event queue and bus register port.
//
// Usage:
//   One input channel (i_valid / o_stall) carries items: key samples, bus
//   address matches, received bytes, byte requests and stop/nack events.
//   One output channel (o_valid / i_stall) returns exactly one result item
//   per input item: the byte for the host, the interrupt request pulse,
//   the backlight duty and the reset request.
// Pipeline and throughput:
//   An item is accepted into a read stage, where the key level memory and
//   the event queue memory are read (synchronous read), then it executes
//   and lands in the output register. One item per cycle is sustained while
//   the output is not stalled; the read-modify-write of both memories is
//   closed by forwarding of the write made in the prior cycle.
// Reset:
//   Control registers return to their defaults, the queue is emptied and all
//   keys read as released through per-key valid bits; no clearing pass.
// Stall:
//   A stalled result holds in the output register while the read stage still
//   takes one more item; after that o_stall rises until the result is taken.
module keypad_event_fifo_i2c_target (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_op,
    input  logic [5:0] i_key_index,
    input  logic       i_pressed,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_int_request,
    output logic [7:0] o_backlight_duty,
    output logic       o_reset_request
);
    import kef_pkg::*;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] last;
        last = QPTR_W'(FIFO_DEPTH - 1);
        return (p == last) ? '0 : p + 1'b1;
    endfunction

    // Handshake control.
    logic accept;
    logic exec;
    logic s1_load;

    // Read stage.
    logic               r_s1_v;
    t_op                r_s1_op;
    logic [5:0]         r_s1_key;
    logic [KADDR_W-1:0] r_s1_key_addr;
    logic               r_s1_key_ok;
    logic               r_s1_pressed;
    logic [7:0]         r_s1_rx;

    logic               key_ok_in;
    logic [KADDR_W-1:0] key_addr_in;

    // Control state.
    t_bus_phase         r_phase, n_phase;
    logic [6:0]         r_sel, n_sel;
    logic [EVENT_W-1:0] r_held, n_held;
    logic [7:0]         r_ctl, n_ctl;
    logic [7:0]         r_int, n_int;
    logic [7:0]         r_bl, n_bl;
    logic [7:0]         r_deb, n_deb;
    logic [7:0]         r_rate, n_rate;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [KEY_TOTAL-1:0] r_key_valid, n_key_valid;

    // Memory ports and forwarding of the prior cycle's write.
    logic               k_we;
    logic [KADDR_W-1:0] k_raddr;
    logic               k_rdata;
    logic               r_kfwd_v;
    logic [KADDR_W-1:0] r_kfwd_addr;
    logic               r_kfwd_data;
    logic               key_level;

    logic               q_we;
    logic [EVENT_W-1:0] q_wdata;
    logic [EVENT_W-1:0] q_rdata;
    logic               r_qfwd_v;
    logic [QPTR_W-1:0]  r_qfwd_addr;
    logic [EVENT_W-1:0] r_qfwd_data;
    logic [EVENT_W-1:0] q_head;
    logic [7:0]         key_num;

    // Result of the executing item.
    logic       res_tx_valid;
    logic [7:0] res_tx_byte;
    logic       res_irq;
    logic       res_rst;

    // Output register.
    logic       r_ov;
    logic       r_o_tx_valid;
    logic [7:0] r_o_tx_byte;
    logic       r_o_irq;
    logic [7:0] r_o_bl;
    logic       r_o_rst;

    // Advance the read stage when the output register frees or is empty.
    assign exec    = r_s1_v && (!r_ov || !i_stall);
    assign s1_load = !r_s1_v || exec;
    assign o_stall = !s1_load;
    assign accept  = i_valid && s1_load;

    // Drop keys outside the matrix; park their memory address at zero.
    assign key_ok_in   = ({3'b000, i_key_index} < 9'(KEY_TOTAL));
    assign key_addr_in = key_ok_in ? KADDR_W'(i_key_index) : '0;
    assign k_raddr     = accept ? key_addr_in : r_s1_key_addr;

    assign key_level = r_key_valid[r_s1_key_addr] &
                       ((r_kfwd_v && (r_kfwd_addr == r_s1_key_addr)) ? r_kfwd_data : k_rdata);
    assign q_head    = (r_qfwd_v && (r_qfwd_addr == r_rd_ptr)) ? r_qfwd_data : q_rdata;
    assign key_num   = 8'(r_s1_key) + 8'd1;
    assign q_wdata   = {key_num, r_s1_pressed};

    kef_ram #(
        .WIDTH (1),
        .DEPTH (KEY_TOTAL)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (r_s1_key_addr),
        .i_wdata (r_s1_pressed),
        .i_raddr (k_raddr),
        .o_rdata (k_rdata)
    );

    // Read the head the next item will see.
    kef_ram #(
        .WIDTH (EVENT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_event_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (q_wdata),
        .i_raddr (n_rd_ptr),
        .o_rdata (q_rdata)
    );

    // Register pointer machine: next phase.
    always_comb begin
        n_phase = r_phase;
        if (exec) begin
            case (r_s1_op)
                OP_ADDR: begin
                    if (r_phase == PH_IDLE) begin
                        n_phase = PH_RX_REG;
                    end
                end
                OP_RX: begin
                    case (r_phase)
                        PH_RX_REG: n_phase = r_s1_rx[WRITE_FLAG_BIT] ? PH_RX_DAT : PH_TX_FIRST;
                        PH_RX_DAT: n_phase = PH_IDLE;
                        default:   n_phase = r_phase;
                    endcase
                end
                OP_TX: begin
                    case (r_phase)
                        PH_TX_FIRST:  n_phase = PH_TX_SECOND;
                        PH_TX_SECOND: n_phase = PH_IDLE;
                        default:      n_phase = r_phase;
                    endcase
                end
                OP_STOP: n_phase = PH_IDLE;
                default: n_phase = r_phase;
            endcase
        end
    end

    // Execute: register updates, queue updates and the result item.
    always_comb begin
        n_sel        = r_sel;
        n_held       = r_held;
        n_ctl        = r_ctl;
        n_int        = r_int;
        n_bl         = r_bl;
        n_deb        = r_deb;
        n_rate       = r_rate;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_count      = r_count;
        n_key_valid  = r_key_valid;
        k_we         = 1'b0;
        q_we         = 1'b0;
        res_tx_valid = 1'b0;
        res_tx_byte  = 8'd0;
        res_irq      = 1'b0;
        res_rst      = 1'b0;
        if (exec) begin
            case (r_s1_op)
                OP_KEY: begin
                    if (r_s1_key_ok && (key_level != r_s1_pressed)) begin
                        k_we                       = 1'b1;
                        n_key_valid[r_s1_key_addr] = 1'b1;
                        n_int[IRQ_KEY_BIT]         = 1'b1;
                        res_irq                    = 1'b1;
                        if (r_count < CNT_W'(FIFO_DEPTH)) begin
                            q_we     = 1'b1;
                            n_wr_ptr = ptr_next(r_wr_ptr);
                            n_count  = r_count + 1'b1;
                        end else begin
                            if (r_ctl[CTL_FLAG_OVF_BIT]) begin
                                n_int[IRQ_OVF_BIT] = 1'b1;
                            end
                            // Overwrite the oldest event.
                            if (r_ctl[CTL_OVERWRITE_BIT]) begin
                                q_we     = 1'b1;
                                n_wr_ptr = ptr_next(r_wr_ptr);
                                n_rd_ptr = ptr_next(r_rd_ptr);
                            end
                        end
                    end
                end
                OP_ADDR: begin
                    if (r_phase == PH_IDLE) begin
                        n_sel = 7'd0;
                    end
                end
                OP_RX: begin
                    if (r_phase == PH_RX_REG) begin
                        n_sel = r_s1_rx[6:0];
                    end else if (r_phase == PH_RX_DAT) begin
                        case (r_sel)
                            REG_CONTROL:   n_ctl   = r_s1_rx;
                            REG_INT:       n_int   = r_s1_rx;
                            REG_BACKLIGHT: n_bl    = r_s1_rx;
                            REG_DEBOUNCE:  n_deb   = r_s1_rx;
                            REG_RATE:      n_rate  = r_s1_rx;
                            REG_RESET:     res_rst = 1'b1;
                            default:       n_sel   = r_sel;
                        endcase
                    end
                end
                OP_TX: begin
                    res_tx_valid = 1'b1;
                    if (r_phase == PH_TX_FIRST) begin
                        case (r_sel)
                            REG_VERSION:   res_tx_byte = VERSION_VALUE;
                            REG_CONTROL:   res_tx_byte = r_ctl;
                            REG_INT:       res_tx_byte = r_int;
                            REG_COUNT:     res_tx_byte = 8'(r_count);
                            REG_BACKLIGHT: res_tx_byte = r_bl;
                            REG_DEBOUNCE:  res_tx_byte = r_deb;
                            REG_RATE:      res_tx_byte = r_rate;
                            REG_EVENT: begin
                                // Dequeue; an empty queue reads as zeros.
                                if (r_count != '0) begin
                                    n_held      = q_head;
                                    n_rd_ptr    = ptr_next(r_rd_ptr);
                                    n_count     = r_count - 1'b1;
                                    res_tx_byte = {7'd0, q_head[0]};
                                end else begin
                                    n_held = '0;
                                end
                            end
                            default:       res_tx_byte = 8'd0;
                        endcase
                    end else if (r_phase == PH_TX_SECOND) begin
                        if (r_sel == REG_EVENT) begin
                            res_tx_byte = r_held[8:1];
                        end
                    end
                end
                default: res_tx_valid = 1'b0;
            endcase
        end
    end

    // Read stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_load) begin
            r_s1_v <= accept;
        end
        if (accept) begin
            r_s1_op       <= t_op'(i_op);
            r_s1_key      <= i_key_index;
            r_s1_key_addr <= key_addr_in;
            r_s1_key_ok   <= key_ok_in;
            r_s1_pressed  <= i_pressed;
            r_s1_rx       <= i_rx_byte;
        end
    end

    // Control state and forwarding.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_sel       <= 7'd0;
            r_held      <= '0;
            r_ctl       <= CTL_RESET;
            r_int       <= 8'd0;
            r_bl        <= 8'd0;
            r_deb       <= DEBOUNCE_RESET;
            r_rate      <= RATE_RESET;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_key_valid <= '0;
            r_kfwd_v    <= 1'b0;
            r_qfwd_v    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_sel       <= n_sel;
            r_held      <= n_held;
            r_ctl       <= n_ctl;
            r_int       <= n_int;
            r_bl        <= n_bl;
            r_deb       <= n_deb;
            r_rate      <= n_rate;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_key_valid <= n_key_valid;
            r_kfwd_v    <= k_we;
            r_qfwd_v    <= q_we;
        end
        r_kfwd_addr <= r_s1_key_addr;
        r_kfwd_data <= r_s1_pressed;
        r_qfwd_addr <= r_wr_ptr;
        r_qfwd_data <= q_wdata;
    end

    // Output register: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            r_ov <= exec;
        end
        if (exec) begin
            r_o_tx_valid <= res_tx_valid;
            r_o_tx_byte  <= res_tx_byte;
            r_o_irq      <= res_irq;
            r_o_bl       <= n_bl;
            r_o_rst      <= res_rst;
        end
    end

    assign o_valid          = r_ov;
    assign o_tx_valid       = r_o_tx_valid;
    assign o_tx_byte        = r_o_tx_byte;
    assign o_int_request    = r_o_irq;
    assign o_backlight_duty = r_o_bl;
    assign o_reset_request  = r_o_rst;

endmodule
